[rtl/pcl_pkg.sv]
package pcl_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 8;
  localparam int CHAR_W = 8;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd3;

  localparam logic [ST_W-1:0] ST_DATA    = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

endpackage

[rtl/pcl_in_if.sv]
interface pcl_in_if import pcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, cmd, position, char_in, input ready);
  modport sink   (input valid, cmd, position, char_in, output ready);
endinterface

[rtl/pcl_out_if.sv]
interface pcl_out_if import pcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, status, char_out, last, input ready);
  modport sink   (input valid, status, char_out, last, output ready);
endinterface

[rtl/positional_char_list.sv]
// channel | dir | handshake           | payload
// in_ch   | in  | valid/ready request | cmd, position, char_in
// out_ch  | out | valid/ready result  | status, char_out, last
//
// Entries live in one sync RAM (registered read); the sequencer owns its ports.
// Get: read on accept, answered in S_RESP. Print: entries in order. Insert:
// S_INS shifts the tail up, then S_INSF writes the char; append and delete of
// the tail: no shift. Delete: S_DEL shifts the rest down. Each shift is paced
// by the RAM ports. Reset empties the list at once; no clearing pass.
// A stalled out_ready holds the result register; the next request is taken
// while it waits.
module positional_char_list import pcl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pcl_in_if.sink    in_ch,
  pcl_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  pcl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pcl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/pcl_mem.sv]
module pcl_mem import pcl_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pcl_ctrl.sv]
module pcl_ctrl import pcl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  pcl_in_if.sink            in_ch,
  pcl_out_if.source         out_ch,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CHAR_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [CHAR_W-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INSF = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_PLD  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     p0_r, p0_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [ST_W-1:0]   rsp_r, rsp_nxt;

  logic              ov_r;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [CHAR_W-1:0] och_r, och_nxt;
  logic              olast_r, olast_nxt;
  logic              out_load;
  logic              out_free;

  logic [POS_W:0]    pos9;
  logic [POS_W:0]    len9;
  logic              pos_zero;
  logic              full;
  logic [LW-1:0]     len_m1;

  assign out_free = !ov_r || out_ch.ready;
  assign pos9     = (POS_W+1)'(in_ch.position);
  assign len9     = (POS_W+1)'(len_r);
  assign pos_zero = (in_ch.position == '0);
  assign full     = (len_r == LW'(CAPACITY));
  assign len_m1   = len_r - LW'(1);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = ov_r;
  assign out_ch.status   = ost_r;
  assign out_ch.char_out = och_r;
  assign out_ch.last     = olast_r;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    p0_nxt    = p0_r;
    ch_nxt    = ch_r;
    rsp_nxt   = rsp_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;
    ost_nxt   = ost_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.cmd)
            CMD_INSERT: begin
              if (full) begin
                rsp_nxt   = ST_FULL;
                state_nxt = S_RESP;
              end else if (pos_zero || pos9 > len9 + (POS_W+1)'(1)) begin
                rsp_nxt   = ST_INVALID;
                state_nxt = S_RESP;
              end else if (pos9 == len9 + (POS_W+1)'(1)) begin
                // append: no shift
                mem_we    = 1'b1;
                mem_waddr = AW'(len_r);
                mem_wdata = in_ch.char_in;
                len_nxt   = len_r + LW'(1);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(len_m1);
                idx_nxt   = AW'(len_r);
                p0_nxt    = AW'(in_ch.position - POS_W'(1));
                ch_nxt    = in_ch.char_in;
                state_nxt = S_INS;
              end
            end
            CMD_DELETE: begin
              if (pos_zero || pos9 > len9) begin
                rsp_nxt   = ST_INVALID;
                state_nxt = S_RESP;
              end else if (pos9 == len9) begin
                len_nxt = len_m1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_ch.position);
                idx_nxt   = AW'(in_ch.position);
                state_nxt = S_DEL;
              end
            end
            CMD_GET: begin
              if (pos_zero || pos9 > len9) begin
                rsp_nxt = ST_INVALID;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_ch.position - POS_W'(1));
                rsp_nxt   = ST_DATA;
              end
              state_nxt = S_RESP;
            end
            CMD_PRINT: begin
              if (len_r == '0) begin
                rsp_nxt   = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_PLD;
              end
            end
          endcase
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (idx_r == p0_r + AW'(1)) begin
          state_nxt = S_INSF;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(2);
          idx_nxt   = idx_r - AW'(1);
        end
      end
      S_INSF: begin
        mem_we    = 1'b1;
        mem_waddr = p0_r;
        mem_wdata = ch_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_IDLE;
      end
      S_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - AW'(1);
        mem_wdata = mem_rdata;
        if (LW'(idx_r) == len_m1) begin
          len_nxt   = len_m1;
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end
      end
      S_PLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          ost_nxt   = ST_DATA;
          och_nxt   = mem_rdata;
          olast_nxt = (LW'(idx_r) == len_m1);
          if (LW'(idx_r) == len_m1) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_r + AW'(1);
            idx_nxt   = idx_r + AW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          ost_nxt   = rsp_r;
          och_nxt   = (rsp_r == ST_DATA) ? mem_rdata : '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    p0_r    <= p0_nxt;
    ch_r    <= ch_nxt;
    rsp_r   <= rsp_nxt;
    ost_r   <= ost_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (len_r == $past(len_r) || len_r == $past(len_r) + LW'(1) ||
              len_r == $past(len_r) - LW'(1)))
    else $error("list length moved by more than one");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLD || state_r == S_RESP) |-> !mem_we)
    else $error("store written during a read-out");

  a_print_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLD && out_load && olast_nxt) |=> state_r == S_IDLE)
    else $error("print did not end after last entry");
`endif

endmodule

[verif/tb.sv]
module tb;
  import pcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIR      = 24;
  localparam int RANDOM_A     = 30;
  localparam int RANDOM_C     = 20;
  localparam int DRAIN_TO     = 16;
  localparam int LONG_STALL   = 300;
  localparam int STALL_AFTER  = 30;
  localparam int TAIL_CYCLES  = CAPACITY_DEF + 8;
  localparam int IDLE_LIMIT   = 3000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } list_req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } list_result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_TYPED} row_kind_t;

  typedef struct packed {
    list_req_t    req;
    row_kind_t    kind;
    list_result_t typed;
  } dir_row_t;

  localparam list_result_t BAD_POS = '{ST_INVALID, 8'h00, 1'b1};

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{CMD_PRINT,  8'h00, 8'h00}, ROW_TYPED,   '{ST_EMPTY, 8'h00, 1'b1}},
    '{'{CMD_GET,    8'h01, 8'h00}, ROW_TYPED,   BAD_POS},
    '{'{CMD_DELETE, 8'h01, 8'h00}, ROW_TYPED,   BAD_POS},
    '{'{CMD_INSERT, 8'h00, 8'h11}, ROW_TYPED,   BAD_POS},
    '{'{CMD_INSERT, 8'h02, 8'h22}, ROW_TYPED,   BAD_POS},
    '{'{CMD_INSERT, 8'h01, 8'h00}, ROW_QUIET,   '0},
    '{'{CMD_INSERT, 8'h02, 8'hFF}, ROW_QUIET,   '0},
    '{'{CMD_GET,    8'h01, 8'hFF}, ROW_TYPED,   '{ST_DATA, 8'h00, 1'b1}},
    '{'{CMD_GET,    8'h02, 8'h00}, ROW_TYPED,   '{ST_DATA, 8'hFF, 1'b1}},
    '{'{CMD_INSERT, 8'h01, 8'hA5}, ROW_QUIET,   '0},
    '{'{CMD_INSERT, 8'h03, 8'h5A}, ROW_QUIET,   '0},
    '{'{CMD_PRINT,  8'hFF, 8'hFF}, ROW_PREDICT, '0},
    '{'{CMD_GET,    8'h00, 8'h00}, ROW_TYPED,   BAD_POS},
    '{'{CMD_GET,    8'hFF, 8'h00}, ROW_TYPED,   BAD_POS},
    '{'{CMD_DELETE, 8'h05, 8'h00}, ROW_TYPED,   BAD_POS},
    '{'{CMD_INSERT, 8'h06, 8'h33}, ROW_TYPED,   BAD_POS},
    '{'{CMD_INSERT, 8'h05, 8'h80}, ROW_QUIET,   '0},
    '{'{CMD_DELETE, 8'h02, 8'h00}, ROW_QUIET,   '0},
    '{'{CMD_DELETE, 8'h04, 8'h00}, ROW_QUIET,   '0},
    '{'{CMD_DELETE, 8'h01, 8'h00}, ROW_QUIET,   '0},
    '{'{CMD_PRINT,  8'h00, 8'h00}, ROW_PREDICT, '0},
    '{'{CMD_GET,    8'h02, 8'h00}, ROW_PREDICT, '0},
    '{'{CMD_DELETE, 8'h00, 8'hFF}, ROW_TYPED,   BAD_POS},
    '{'{CMD_PRINT,  8'h80, 8'h7F}, ROW_PREDICT, '0}
  };

  logic clk;
  logic rst_n;

  pcl_in_if  in_ch();
  pcl_out_if out_ch();

  positional_char_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [CHAR_W-1:0] seq_bytes[$];
  list_result_t      op_results[$];
  list_result_t      awaited_results[$];
  int                accepted_requests = 0;
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  bit                idle_enable = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void apply_list_op(input list_req_t r);
    int unsigned len;
    int unsigned p;
    len = seq_bytes.size();
    p = r.position;
    op_results.delete();
    case (r.cmd)
      CMD_INSERT: begin
        if (len >= CAPACITY_DEF) op_results.push_back('{ST_FULL, 8'h00, 1'b1});
        else if (p == 0 || p > len + 1) op_results.push_back(BAD_POS);
        else seq_bytes.insert(p - 1, r.char_in);
      end
      CMD_DELETE: begin
        if (p == 0 || p > len) op_results.push_back(BAD_POS);
        else seq_bytes.delete(p - 1);
      end
      CMD_GET: begin
        if (p == 0 || p > len) op_results.push_back(BAD_POS);
        else op_results.push_back('{ST_DATA, seq_bytes[p-1], 1'b1});
      end
      default: begin
        if (len == 0) begin
          op_results.push_back('{ST_EMPTY, 8'h00, 1'b1});
        end else begin
          for (int unsigned i = 0; i < len; i++)
            op_results.push_back('{ST_DATA, seq_bytes[i], 1'(i + 1 == len)});
        end
      end
    endcase
  endfunction

  function automatic list_req_t pick_request(input bit well_formed);
    list_req_t   r;
    int unsigned len;
    int unsigned roll;
    len = seq_bytes.size();
    roll = $urandom_range(0, 19);
    r.char_in = CHAR_W'($urandom_range(0, 255));
    if (roll < 7) r.cmd = CMD_INSERT;
    else if (roll < 12) r.cmd = CMD_DELETE;
    else if (roll < 17) r.cmd = CMD_GET;
    else r.cmd = CMD_PRINT;
    if (!well_formed) begin
      if ($urandom_range(0, 1) == 0) r.position = POS_W'($urandom_range(0, 255));
      else r.position = POS_W'($urandom_range(len + 1, len + 2));
    end else if (r.cmd == CMD_INSERT) begin
      r.position = POS_W'($urandom_range(1, len + 1));
    end else begin
      r.position = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, len));
    end
    return r;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic send_request(input list_req_t r, input row_kind_t kind,
                              input list_result_t typed);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= r.cmd;
    in_ch.position <= r.position;
    in_ch.char_in  <= r.char_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted_requests++;
    apply_list_op(r);
    if (kind == ROW_TYPED) awaited_results.push_back(typed);
    else if (kind == ROW_PREDICT)
      foreach (op_results[i]) awaited_results.push_back(op_results[i]);
  endtask

  initial begin : request_source
    list_req_t r;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_INSERT;
    in_ch.position <= '0;
    in_ch.char_in  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++)
      send_request(DIR_ROWS[i].req, DIR_ROWS[i].kind, DIR_ROWS[i].typed);

    for (int i = 0; i < RANDOM_A; i++)
      send_request(pick_request($urandom_range(0, 7) != 0), ROW_PREDICT, '0);

    // fill up, hit the full store, then drain partway
    while (seq_bytes.size() < CAPACITY_DEF) begin
      r.cmd      = CMD_INSERT;
      r.position = POS_W'($urandom_range(1, seq_bytes.size() + 1));
      r.char_in  = CHAR_W'($urandom_range(0, 255));
      send_request(r, ROW_PREDICT, '0);
    end
    send_request('{CMD_INSERT, 8'h00, 8'h01}, ROW_PREDICT, '0);
    send_request('{CMD_INSERT, 8'hFF, 8'hFE}, ROW_PREDICT, '0);
    send_request('{CMD_INSERT, POS_W'($urandom_range(1, CAPACITY_DEF + 1)), 8'h42},
                 ROW_PREDICT, '0);
    send_request('{CMD_PRINT, 8'h00, 8'h00}, ROW_PREDICT, '0);
    send_request('{CMD_GET, POS_W'(CAPACITY_DEF), 8'h00}, ROW_PREDICT, '0);
    send_request('{CMD_GET, POS_W'(CAPACITY_DEF + 1), 8'h00}, ROW_PREDICT, '0);
    send_request('{CMD_DELETE, POS_W'(CAPACITY_DEF + 1), 8'h00}, ROW_PREDICT, '0);
    while (seq_bytes.size() > DRAIN_TO) begin
      r.cmd      = CMD_DELETE;
      r.position = POS_W'($urandom_range(1, seq_bytes.size()));
      r.char_in  = CHAR_W'($urandom_range(0, 255));
      send_request(r, ROW_PREDICT, '0);
    end

    idle_enable = 1'b0;
    for (int i = 0; i < RANDOM_C; i++)
      send_request(pick_request($urandom_range(0, 7) != 0), ROW_PREDICT, '0);
    in_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    bit stall_done;
    stall_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!stall_done && accepted_requests >= STALL_AFTER) begin
        stall_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result: status=%0d char=%02h last=%0b",
                               out_ch.status, out_ch.char_out, out_ch.last));
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status || out_ch.char_out !== want.char_out ||
            out_ch.last !== want.last)
          log_mismatch($sformatf(
            "result mismatch: exp status=%0d char=%02h last=%0b, got status=%0d char=%02h last=%0b",
            want.status, want.char_out, want.last,
            out_ch.status, out_ch.char_out, out_ch.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d results still awaited", awaited_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

[files.f]
rtl/pcl_pkg.sv
rtl/pcl_in_if.sv
rtl/pcl_out_if.sv
rtl/pcl_mem.sv
rtl/pcl_ctrl.sv
rtl/positional_char_list.sv
verif/tb.sv
